[rtl/rnt_pkg.sv]
// ring node table: shared types and constants
// word layouts for the input, result and table entry, plus opcode names
// no dependencies
`default_nettype none

package rnt_pkg;

    localparam int RNT_DEPTH = 64;
    localparam int ID_BITS   = 32;
    localparam int TIME_BITS = 32;
    localparam int OP_BITS   = 3;
    localparam int CNT_BITS  = 7;

    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [OP_BITS-1:0] {
        OP_UPDATE  = 3'd0,
        OP_FIND    = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_NEAREST = 3'd3,
        OP_AUDIT   = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [OP_BITS-1:0] opcode;
        t_id                node_id;
        logic               routable;
        t_time              now_ms;
    } t_in_word;

    typedef struct packed {
        logic                found;
        t_id                 result_id;
        logic [CNT_BITS-1:0] entry_count;
        logic                table_full;
    } t_out_word;

    typedef struct packed {
        logic  valid;
        logic  routable;
        t_id   ident;
        t_time last_seen;
    } t_entry;

endpackage

`default_nettype wire

[rtl/rnt_ram.sv]
// ring node table: generic simple dual port ram
// one write port, one read port with registered read data, no dependencies
`default_nettype none

module rnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/ring_node_table_nearest_lookup_core.sv]
// ring node table with update, find, remove, nearest and audit
// depends on rnt_pkg and rnt_ram
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-----------------------
//   in      | input     | i_in_valid/o_in_stall   | t_in_word
//   out     | output    | o_out_valid/i_out_stall | t_out_word
//   cfg     | input     | i_cfg_valid/o_cfg_ready | stale interval, ms
//
// every word scans the whole table through the single ram read port, one entry
// a cycle, and its result is then registered in the output register
// after reset a clearing pass writes every entry to zero before the first word
// the next word is accepted while a result still waits in the output register
// a result only stalls the block when the output register is still occupied
`default_nettype none

module ring_node_table_nearest_lookup_core
    import rnt_pkg::*;
#(
    parameter int TABLE_DEPTH = RNT_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire t_time     i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(t_entry);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_all, n_all;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic [OP_BITS-1:0] r_op, n_op;
    t_id                r_id, n_id;
    logic               r_rt, n_rt;
    t_time              r_now, n_now;
    t_time              r_interval, n_interval;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_hit, n_hit;
    logic [AW-1:0]      r_hit_idx, n_hit_idx;
    logic               r_hit_rt, n_hit_rt;
    logic               r_free, n_free;
    logic [AW-1:0]      r_free_idx, n_free_idx;
    logic               r_have_in, n_have_in;
    t_id                r_best_in, n_best_in;
    logic               r_have_any, n_have_any;
    t_id                r_best_any, n_best_any;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic [EW-1:0]      ram_rdata;
    t_entry             rd;

    logic               match, stale, drop, keep, near_ok, out_free;
    logic [CW+CNT_BITS-1:0] cnt_wide;

    rnt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_entry'(ram_rdata);
    assign match    = rd.valid && (rd.ident == r_id);
    assign stale    = rd.valid && (({1'b0, rd.last_seen} + {1'b0, r_interval}) < {1'b0, r_now});
    assign drop     = ((r_op == OP_REMOVE) && match) || ((r_op == OP_AUDIT) && stale);
    assign keep     = rd.valid && !drop;
    assign near_ok  = (rd.ident != '0) && (rd.ident <= r_id);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_wide = {{CNT_BITS{1'b0}}, r_cnt};

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_all      = r_all;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_op       = r_op;
        n_id       = r_id;
        n_rt       = r_rt;
        n_now      = r_now;
        n_interval = r_interval;
        n_cnt      = r_cnt;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_rt   = r_hit_rt;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_have_in  = r_have_in;
        n_best_in  = r_best_in;
        n_have_any = r_have_any;
        n_best_any = r_best_any;
        n_out_valid = r_out_valid && i_out_stall;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_pidx;
        ram_wdata  = rd;

        if (i_cfg_valid) begin
            n_interval = i_cfg_data;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = '0;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in_word.opcode;
                    n_id       = i_in_word.node_id;
                    n_rt       = i_in_word.routable;
                    n_now      = i_in_word.now_ms;
                    n_idx      = '0;
                    n_all      = 1'b0;
                    n_pend     = 1'b0;
                    n_cnt      = '0;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    n_have_in  = 1'b0;
                    n_have_any = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_all) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_all = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_cnt = r_cnt + CW'(keep);
                    if (drop) begin
                        ram_we          = 1'b1;
                        ram_wdata.valid = 1'b0;
                    end
                    if (match && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_pidx;
                        n_hit_rt  = rd.routable;
                    end
                    if (!rd.valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pidx;
                    end
                    if (rd.valid && rd.routable) begin
                        if (near_ok && (!r_have_in || (rd.ident > r_best_in))) begin
                            n_have_in = 1'b1;
                            n_best_in = rd.ident;
                        end
                        if (!r_have_any || (rd.ident > r_best_any)) begin
                            n_have_any = 1'b1;
                            n_best_any = rd.ident;
                        end
                    end
                end
                if (r_all && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_op)
                        OP_UPDATE: begin
                            ram_wdata.valid     = 1'b1;
                            ram_wdata.ident     = r_id;
                            ram_wdata.last_seen = r_now;
                            if (r_hit) begin
                                ram_we             = 1'b1;
                                ram_waddr          = r_hit_idx;
                                ram_wdata.routable = r_hit_rt;
                            end else if (r_free) begin
                                ram_we             = 1'b1;
                                ram_waddr          = r_free_idx;
                                ram_wdata.routable = r_rt;
                                n_cnt              = r_cnt + 1'b1;
                            end else begin
                                n_out.table_full = 1'b1;
                            end
                        end
                        OP_FIND: begin
                            n_out.found     = r_hit;
                            n_out.result_id = r_hit ? r_id : '0;
                        end
                        OP_NEAREST: begin
                            n_out.found = r_have_in || r_have_any;
                            if (r_have_in) begin
                                n_out.result_id = r_best_in;
                            end else if (r_have_any) begin
                                n_out.result_id = r_best_any;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.entry_count = (r_op == OP_UPDATE && !r_hit && r_free)
                        ? cnt_wide[CNT_BITS-1:0] + 1'b1 : cnt_wide[CNT_BITS-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_all       <= 1'b0;
            r_pend      <= 1'b0;
            r_interval  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_all       <= n_all;
            r_pend      <= n_pend;
            r_interval  <= n_interval;
            r_out_valid <= n_out_valid;
        end
        r_pidx     <= n_pidx;
        r_op       <= n_op;
        r_id       <= n_id;
        r_rt       <= n_rt;
        r_now      <= n_now;
        r_cnt      <= n_cnt;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_rt   <= n_hit_rt;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_have_in  <= n_have_in;
        r_best_in  <= n_best_in;
        r_have_any <= n_have_any;
        r_best_any <= n_best_any;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[rtl/rnt_checker.sv]
// ring node table: port level checks, bound to the top level
// depends on rnt_pkg and ring_node_table_nearest_lookup_core
`default_nettype none

module rnt_checker
    import rnt_pkg::*;
#(
    parameter int TABLE_DEPTH = RNT_DEPTH
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // pending result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // accepted word keeps the block busy for its scan
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({25'b0, o_out_word.entry_count} <= 32'(TABLE_DEPTH)))
        else $error("entry count beyond table depth");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.table_full |->
            !o_out_word.found && (o_out_word.result_id == '0))
        else $error("full flag with a lookup result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |-> (o_out_word.result_id == '0))
        else $error("identifier reported without a hit");

endmodule

bind ring_node_table_nearest_lookup_core rnt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_rnt_checker (.*);

`default_nettype wire

[test/ring_node_table_nearest_lookup_core_test.sv]
`timescale 1ns / 1ps
// testbench for ring_node_table_nearest_lookup_core: directed and random table
// operations checked against an in-bench model of the table, with random idling
// depends on rnt_pkg and the core rtl

module ring_node_table_nearest_lookup_core_test;
    import rnt_pkg::*;

    localparam logic [OP_BITS-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_BITS-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_RSVD_7 = 3'd7;
    localparam t_id  ID_MAX   = {ID_BITS{1'b1}};
    localparam t_time TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      i_cfg_valid = 1'b0;
    t_time     i_cfg_data  = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      o_cfg_ready;

    // table model
    bit    tbl_valid    [RNT_DEPTH];
    t_id   tbl_ident    [RNT_DEPTH];
    bit    tbl_routable [RNT_DEPTH];
    t_time tbl_seen     [RNT_DEPTH];
    t_time stale_ms = '0;

    t_out_word table_replies_due[$];
    int        fail_count = 0;

    t_id   id_pool[128];
    t_time clock_ms = '0;
    int    burst_left = 0;
    bit    gaps_on = 1'b1;

    int          hold_request = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    int          stall_phase = 0;
    t_stall_mode stall_mode = STALL_NONE;

    ring_node_table_nearest_lookup_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("ring_node_table_nearest_lookup_core verification failed");
        $finish;
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ((stall_phase % 5) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (table_replies_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, o_out_word);
                fail_count++;
            end else begin
                want = table_replies_due.pop_front();
                if (o_out_word.found !== want.found) begin
                    $display("%0t: found mismatch, expected %h, actual %h",
                             $time, want.found, o_out_word.found);
                    fail_count++;
                end
                if (o_out_word.result_id !== want.result_id) begin
                    $display("%0t: result_id mismatch, expected %h, actual %h",
                             $time, want.result_id, o_out_word.result_id);
                    fail_count++;
                end
                if (o_out_word.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                             $time, want.entry_count, o_out_word.entry_count);
                    fail_count++;
                end
                if (o_out_word.table_full !== want.table_full) begin
                    $display("%0t: table_full mismatch, expected %h, actual %h",
                             $time, want.table_full, o_out_word.table_full);
                    fail_count++;
                end
            end
        end
    end

    function automatic int slot_of(input t_id id);
        for (int i = 0; i < RNT_DEPTH; i++)
            if (tbl_valid[i] && tbl_ident[i] == id)
                return i;
        return -1;
    endfunction

    task automatic apply_table_op(input t_in_word w);
        t_out_word r;
        int        slot;
        int        n;
        bit        have_in;
        bit        have_any;
        t_id       best_in;
        t_id       best_any;
        r = '0;
        n = 0;
        have_in = 1'b0;
        have_any = 1'b0;
        best_in = '0;
        best_any = '0;
        slot = slot_of(w.node_id);
        case (w.opcode)
            OP_UPDATE: begin
                if (slot >= 0) begin
                    tbl_seen[slot] = w.now_ms;
                end else begin
                    for (int i = RNT_DEPTH - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            slot = i;
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_ident[slot] = w.node_id;
                        tbl_routable[slot] = w.routable;
                        tbl_seen[slot] = w.now_ms;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
            end
            OP_FIND: begin
                if (slot >= 0) begin
                    r.found = 1'b1;
                    r.result_id = w.node_id;
                end
            end
            OP_REMOVE: begin
                if (slot >= 0)
                    tbl_valid[slot] = 1'b0;
            end
            OP_NEAREST: begin
                for (int i = 0; i < RNT_DEPTH; i++) begin
                    if (tbl_valid[i] && tbl_routable[i]) begin
                        if (tbl_ident[i] != 0 && tbl_ident[i] <= w.node_id &&
                            (!have_in || tbl_ident[i] > best_in)) begin
                            best_in = tbl_ident[i];
                            have_in = 1'b1;
                        end
                        if (!have_any || tbl_ident[i] > best_any) begin
                            best_any = tbl_ident[i];
                            have_any = 1'b1;
                        end
                    end
                end
                if (have_in) begin
                    r.found = 1'b1;
                    r.result_id = best_in;
                end else if (have_any) begin
                    r.found = 1'b1;
                    r.result_id = best_any;
                end
            end
            OP_AUDIT: begin
                // exact compare, one bit wider so the sum cannot wrap
                for (int i = 0; i < RNT_DEPTH; i++)
                    if (tbl_valid[i] &&
                        ({1'b0, tbl_seen[i]} + {1'b0, stale_ms} < {1'b0, w.now_ms}))
                        tbl_valid[i] = 1'b0;
            end
            default: ;
        endcase
        for (int i = 0; i < RNT_DEPTH; i++)
            n += tbl_valid[i];
        r.entry_count = CNT_BITS'(n);
        table_replies_due.push_back(r);
    endtask

    function automatic t_in_word make_word(input logic [OP_BITS-1:0] op, input t_id id,
                                           input logic rt, input t_time now);
        t_in_word w;
        w.opcode = op;
        w.node_id = id;
        w.routable = rt;
        w.now_ms = now;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 5) : $urandom_range(6, 90);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_word = w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        apply_table_op(w);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (table_replies_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_stale_interval(input t_time value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        stale_ms = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_random_word(input int pool_n, input int update_pct);
        t_in_word w;
        int       pick;
        w = '0;
        w.routable = 1'($urandom_range(0, 1));
        w.node_id = id_pool[$urandom_range(0, pool_n - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 10)
            w.node_id = w.node_id + 1;
        else if (pick < 20)
            w.node_id = w.node_id - 1;
        else if (pick < 32)
            w.node_id = $urandom();
        clock_ms = clock_ms + $urandom_range(0, 40);
        w.now_ms = ($urandom_range(0, 15) == 0) ? t_time'($urandom()) : clock_ms;
        if ($urandom_range(0, 99) < update_pct) begin
            w.opcode = OP_UPDATE;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                w.opcode = OP_FIND;
            end else if (pick < 50) begin
                w.opcode = OP_REMOVE;
            end else if (pick < 80) begin
                w.opcode = OP_NEAREST;
                if ($urandom_range(0, 9) == 0)
                    w.node_id = '0;
            end else if (pick < 95) begin
                w.opcode = OP_AUDIT;
                if ($urandom_range(0, 3) != 0)
                    w.now_ms = clock_ms + $urandom_range(0, 300);
            end else begin
                w.opcode = OP_BITS'(OP_RSVD_5 + $urandom_range(0, 2));
            end
        end
        send_word(w);
    endtask

    task automatic test_directed_ops();
        send_word(make_word(OP_NEAREST, '0, 1'b1, '0));
        send_word(make_word(OP_AUDIT, ID_MAX, 1'b1, TIME_MAX));
        send_word(make_word(OP_UPDATE, '0, 1'b1, '0));
        send_word(make_word(OP_UPDATE, ID_MAX, 1'b1, TIME_MAX));
        send_word(make_word(OP_UPDATE, 32'h8000_0000, 1'b0, 32'd5));
        send_word(make_word(OP_UPDATE, 32'h1234_5678, 1'b1, 32'd10));
        send_word(make_word(OP_UPDATE, 32'h8000_0000, 1'b1, 32'd20));
        send_word(make_word(OP_FIND, 32'h1234_5678, 1'b0, '0));
        send_word(make_word(OP_FIND, 32'h1234_5679, 1'b1, TIME_MAX));
        send_word(make_word(OP_NEAREST, '0, 1'b0, '0));
        send_word(make_word(OP_NEAREST, 32'h8000_0000, 1'b0, '0));
        send_word(make_word(OP_NEAREST, 32'h1234_5677, 1'b0, '0));
        send_word(make_word(OP_NEAREST, ID_MAX, 1'b1, TIME_MAX));
        send_word(make_word(OP_REMOVE, 32'h5555_5555, 1'b0, '0));
        send_word(make_word(OP_REMOVE, ID_MAX, 1'b0, '0));
        send_word(make_word(OP_NEAREST, 32'd1, 1'b0, '0));
        send_word(make_word(OP_RSVD_5, ID_MAX, 1'b1, TIME_MAX));
        send_word(make_word(OP_RSVD_6, ID_MAX, 1'b1, TIME_MAX));
        send_word(make_word(OP_RSVD_7, ID_MAX, 1'b1, TIME_MAX));
        send_word(make_word(OP_AUDIT, '0, 1'b0, TIME_MAX));
        send_word(make_word(OP_NEAREST, ID_MAX, 1'b0, '0));
        send_word(make_word(OP_UPDATE, 32'hAAAA_AAAA, 1'b0, '0));
        send_word(make_word(OP_NEAREST, ID_MAX, 1'b1, '0));
        send_word(make_word(OP_FIND, '0, 1'b0, '0));
        drain_results();
    endtask

    task automatic test_stale_audit();
        write_stale_interval('0);
        send_word(make_word(OP_UPDATE, 32'h0000_1000, 1'b1, 32'd100));
        send_word(make_word(OP_AUDIT, '0, 1'b0, 32'd100));
        send_word(make_word(OP_AUDIT, '0, 1'b0, 32'd101));
        drain_results();
        write_stale_interval(TIME_MAX);
        send_word(make_word(OP_UPDATE, 32'h0000_2000, 1'b1, '0));
        send_word(make_word(OP_AUDIT, '0, 1'b0, TIME_MAX));
        drain_results();
        write_stale_interval(TIME_MAX - 1);
        send_word(make_word(OP_AUDIT, '0, 1'b0, TIME_MAX));
        drain_results();
        write_stale_interval(32'd5);
        send_word(make_word(OP_UPDATE, 32'h0000_3000, 1'b1, 32'hFFFF_FFF0));
        send_word(make_word(OP_AUDIT, '0, 1'b0, 32'hFFFF_FFF5));
        send_word(make_word(OP_AUDIT, '0, 1'b0, 32'hFFFF_FFF6));
        drain_results();
        write_stale_interval($urandom_range(50, 400));
        clock_ms = $urandom_range(0, 1000);
        repeat (50) send_random_word(24, 50);
        drain_results();
    endtask

    task automatic test_table_full();
        t_id ids[70];
        write_stale_interval('0);
        send_word(make_word(OP_AUDIT, '0, 1'b0, TIME_MAX));
        drain_results();
        write_stale_interval(TIME_MAX);
        for (int i = 0; i < 70; i++) begin
            ids[i] = ($urandom() & 32'hFFFF_FF00) | i;
            send_word(make_word(OP_UPDATE, ids[i], 1'($urandom_range(0, 1)), $urandom()));
        end
        send_word(make_word(OP_UPDATE, ids[3], 1'b1, TIME_MAX));
        send_word(make_word(OP_FIND, ids[10], 1'b0, '0));
        send_word(make_word(OP_FIND, ids[68], 1'b0, '0));
        send_word(make_word(OP_NEAREST, ids[20], 1'b0, '0));
        send_word(make_word(OP_NEAREST, '0, 1'b0, '0));
        for (int i = 0; i < 3; i++)
            send_word(make_word(OP_REMOVE, ids[5 * i + 1], 1'b0, '0));
        for (int i = 65; i < 69; i++)
            send_word(make_word(OP_UPDATE, ids[i], 1'($urandom_range(0, 1)), $urandom()));
        send_word(make_word(OP_AUDIT, '0, 1'b0, TIME_MAX));
        repeat (40) send_random_word(128, 50);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        send_random_word(48, 40);
        hold_request = 600;
        repeat (30) send_random_word(48, 40);
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_mix();
        t_time interval;
        int    pool_n;
        int    update_pct;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: interval = '0;
                1: interval = TIME_MAX;
                2: interval = $urandom_range(1, 400);
                3: interval = $urandom_range(400, 4000);
                4: interval = $urandom();
                default: interval = 32'd1;
            endcase
            write_stale_interval(interval);
            gaps_on = (phase != 2);
            pool_n = (phase == 1) ? 128 : 48;
            update_pct = (phase == 1) ? 55 : 35;
            if (phase == 4)
                clock_ms = TIME_MAX - $urandom_range(0, 2000);
            repeat (220) send_random_word(pool_n, update_pct);
            drain_results();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        id_pool[0] = '0;
        id_pool[1] = 32'd1;
        id_pool[2] = ID_MAX;
        id_pool[3] = 32'h8000_0000;
        for (int i = 4; i < 16; i++)
            id_pool[i] = $urandom_range(2, 64);
        for (int i = 16; i < 128; i++)
            id_pool[i] = $urandom();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ops();
        test_stale_audit();
        test_table_full();
        test_output_backpressure();
        test_random_mix();

        drain_results();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("ring_node_table_nearest_lookup_core verification clean");
        else
            $display("ring_node_table_nearest_lookup_core verification failed");
        $finish;
    end

endmodule
